// ===== rtl/core/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and helpers of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int HEAP_BYTES = 65536;
    localparam int GRAN_BYTES = 8;
    localparam int GRANULES   = HEAP_BYTES / GRAN_BYTES;
    localparam int GIDX_W     = $clog2(GRANULES);
    localparam int PTR_W      = GIDX_W + 1;
    localparam int SIZE_W     = 17;
    localparam int SPAN_W     = 18;
    localparam int LINK_BYTES = 16;
    localparam int CFG_W      = 17;
    localparam logic [CFG_W-1:0] HEAP_RESET = CFG_W'(HEAP_BYTES);

    typedef logic [PTR_W-1:0] t_ptr;
    localparam t_ptr NIL = '1;

    typedef struct packed {
        t_ptr              prev;
        t_ptr              next;
        logic              used;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    typedef struct packed {
        logic              we;
        logic [GIDX_W-1:0] waddr;
        t_hdr              wdata;
        logic [GIDX_W-1:0] raddr;
    } t_ram_req;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ZERO  = 3'd1,
        ST_OOM   = 3'd2,
        ST_FREED = 3'd3,
        ST_NULL  = 3'd4
    } t_status;

    // status sits in the low bits when packed into a beat
    typedef struct packed {
        logic [11:0] live;
        logic [16:0] used_total;
        logic [15:0] data_addr;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_eng_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_PRE,
        S_A_WRD,
        S_A_WCHK,
        S_A_RM,
        S_A_RM2,
        S_A_SPLIT,
        S_A_BRK,
        S_A_FIN,
        S_F_PRE,
        S_F_RD,
        S_F_CHK,
        S_I_START,
        S_I_WRD,
        S_I_WCHK,
        S_I_MX,
        S_I_MXRD,
        S_I_MXMRG,
        S_I_MI,
        S_I_WRX,
        S_I_WRI,
        S_FIX_RD,
        S_FIX_WR,
        S_DONE
    } t_state;

    // bytes covered by a block: header plus data of at least two links
    function automatic logic [SPAN_W-1:0] span(input logic [SPAN_W-1:0] s);
        logic [SPAN_W-1:0] d;
        d = (s >= SPAN_W'(LINK_BYTES)) ? s : SPAN_W'(LINK_BYTES);
        return SPAN_W'(GRAN_BYTES) + d;
    endfunction

    function automatic logic ptr_ok(input t_ptr p);
        return !p[PTR_W-1];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ffha_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// Header memory, one header per granule, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_hdr_ram (
    input  wire               i_clk,
    input  ffha_pkg::t_ram_req i_req,
    output ffha_pkg::t_hdr    o_rdata
);

    ffha_pkg::t_hdr r_mem [ffha_pkg::GRANULES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ffha_engine.sv =====
// ----------------------------------------------------------------------------
// ffha_engine
// Sequencer that walks and edits the address-ordered free list in header memory.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_engine (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire                           i_req_free,
    input  wire [16:0]                    i_req_bytes,
    input  wire [15:0]                    i_free_addr,
    input  wire [ffha_pkg::CFG_W-1:0]     i_heap_bytes,
    input  wire                           i_res_take,
    output ffha_pkg::t_eng_stat           o_stat,
    output ffha_pkg::t_result             o_result,
    output ffha_pkg::t_ram_req            o_ram,
    input  ffha_pkg::t_hdr                i_ram_rdata
);

    localparam int GW = ffha_pkg::GIDX_W;
    localparam int SW = ffha_pkg::SPAN_W;
    localparam int ZW = ffha_pkg::SIZE_W;

    ffha_pkg::t_state  r_state, n_state, r_ret, n_ret;
    logic              r_is_free, n_is_free;
    logic [SW-1:0]     r_size, n_size, r_adj, n_adj;
    ffha_pkg::t_ptr    r_head, n_head, r_it, n_it;
    logic [16:0]       r_brk, n_brk, r_used, n_used;
    logic [11:0]       r_live, n_live;
    logic [GW-1:0]     r_g, n_g, r_xi, n_xi, r_fix_addr, n_fix_addr;
    ffha_pkg::t_hdr    r_gh, n_gh, r_xh, n_xh, r_ih, n_ih;
    logic              r_has_it, n_has_it, r_fix_nxt, n_fix_nxt;
    ffha_pkg::t_ptr    r_fix_val, n_fix_val;
    ffha_pkg::t_status r_status, n_status;
    logic [15:0]       r_daddr, n_daddr, r_addr, n_addr;

    ffha_pkg::t_hdr    rd;
    logic              w_head_ok, w_fit, w_walk_on, w_split_ok, w_rem_ok, w_oom;
    logic              w_mx, w_mi, w_null, w_bad;
    logic [SW-1:0]     w_gsz, w_diff;
    logic [GW+1:0]     w_rem;
    logic [16:0]       w_hb, w_lim;
    logic [SW:0]       w_brk_end;
    logic [SW-1:0]     w_x_end, w_i_end;

    assign rd         = i_ram_rdata;
    assign w_head_ok  = ffha_pkg::ptr_ok(r_head);
    assign w_fit      = !rd.used && (r_size <= {1'b0, rd.size});
    assign w_walk_on  = ffha_pkg::ptr_ok(rd.next) && (r_xi > rd.next[GW-1:0]);
    assign w_gsz      = {1'b0, r_gh.size};
    assign w_diff     = w_gsz - r_adj;
    assign w_split_ok = (w_gsz >= r_adj) && (w_diff >= SW'(ffha_pkg::LINK_BYTES));
    assign w_rem      = {2'b00, r_g} + (GW+2)'(r_adj[SW-1:3]);
    assign w_rem_ok   = w_rem < (GW+2)'(ffha_pkg::GRANULES);
    assign w_hb       = {i_heap_bytes[16:3], 3'b000};
    assign w_lim      = (w_hb > 17'(ffha_pkg::HEAP_BYTES)) ? 17'(ffha_pkg::HEAP_BYTES) : w_hb;
    assign w_brk_end  = {2'b00, r_brk} + {1'b0, r_adj};
    assign w_oom      = (w_brk_end > {2'b00, w_lim}) ||
                        (r_brk >= 17'(ffha_pkg::HEAP_BYTES));
    // block end in bytes against the neighbor's header offset
    assign w_x_end    = SW'({r_xi, 3'b000}) + ffha_pkg::span({1'b0, r_xh.size});
    assign w_i_end    = SW'({r_it[GW-1:0], 3'b000}) + ffha_pkg::span({1'b0, r_ih.size});
    assign w_mx       = ffha_pkg::ptr_ok(r_xh.next) &&
                        (w_x_end == SW'({r_xh.next[GW-1:0], 3'b000}));
    assign w_mi       = r_has_it && (w_i_end == SW'({r_xi, 3'b000}));
    assign w_null     = (r_addr == 16'd0);
    assign w_bad      = (r_addr < 16'd8) || (r_addr[2:0] != 3'd0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = i_req_free ? ffha_pkg::S_F_PRE : ffha_pkg::S_A_PRE;
                end
            end
            ffha_pkg::S_A_PRE: begin
                if (r_size == '0 || i_heap_bytes == '0) begin
                    n_state = ffha_pkg::S_DONE;
                end else if (w_head_ok) begin
                    n_state = ffha_pkg::S_A_WRD;
                end else begin
                    n_state = ffha_pkg::S_A_BRK;
                end
            end
            ffha_pkg::S_A_WRD: n_state = ffha_pkg::S_A_WCHK;
            ffha_pkg::S_A_WCHK: begin
                if (w_fit) begin
                    n_state = ffha_pkg::S_A_RM;
                end else if (ffha_pkg::ptr_ok(rd.next)) begin
                    n_state = ffha_pkg::S_A_WRD;
                end else begin
                    n_state = ffha_pkg::S_A_BRK;
                end
            end
            ffha_pkg::S_A_RM: begin
                n_state = ffha_pkg::ptr_ok(r_gh.prev) ? ffha_pkg::S_FIX_RD
                                                      : ffha_pkg::S_A_RM2;
            end
            ffha_pkg::S_A_RM2: begin
                n_state = ffha_pkg::ptr_ok(r_gh.next) ? ffha_pkg::S_FIX_RD
                                                      : ffha_pkg::S_A_SPLIT;
            end
            ffha_pkg::S_A_SPLIT: begin
                n_state = (w_split_ok && w_rem_ok) ? ffha_pkg::S_I_START
                                                   : ffha_pkg::S_A_FIN;
            end
            ffha_pkg::S_A_BRK: n_state = w_oom ? ffha_pkg::S_DONE : ffha_pkg::S_A_FIN;
            ffha_pkg::S_A_FIN: n_state = ffha_pkg::S_DONE;
            ffha_pkg::S_F_PRE: begin
                n_state = (w_null || w_bad) ? ffha_pkg::S_DONE : ffha_pkg::S_F_RD;
            end
            ffha_pkg::S_F_RD: n_state = ffha_pkg::S_F_CHK;
            ffha_pkg::S_F_CHK: begin
                n_state = rd.used ? ffha_pkg::S_I_START : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_I_START: begin
                if (!w_head_ok) begin
                    n_state = ffha_pkg::S_I_WRX;
                end else if (r_xi < r_head[GW-1:0]) begin
                    n_state = ffha_pkg::S_FIX_RD;
                end else begin
                    n_state = ffha_pkg::S_I_WRD;
                end
            end
            ffha_pkg::S_I_WRD: n_state = ffha_pkg::S_I_WCHK;
            ffha_pkg::S_I_WCHK: begin
                if (w_walk_on) begin
                    n_state = ffha_pkg::S_I_WRD;
                end else if (ffha_pkg::ptr_ok(rd.next)) begin
                    n_state = ffha_pkg::S_FIX_RD;
                end else begin
                    n_state = ffha_pkg::S_I_MX;
                end
            end
            ffha_pkg::S_I_MX: n_state = w_mx ? ffha_pkg::S_I_MXRD : ffha_pkg::S_I_MI;
            ffha_pkg::S_I_MXRD: n_state = ffha_pkg::S_I_MXMRG;
            ffha_pkg::S_I_MXMRG: begin
                n_state = ffha_pkg::ptr_ok(rd.next) ? ffha_pkg::S_FIX_RD : ffha_pkg::S_I_MI;
            end
            ffha_pkg::S_I_MI: begin
                n_state = (w_mi && ffha_pkg::ptr_ok(r_xh.next)) ? ffha_pkg::S_FIX_RD
                                                                : ffha_pkg::S_I_WRX;
            end
            ffha_pkg::S_I_WRX: begin
                if (r_has_it) begin
                    n_state = ffha_pkg::S_I_WRI;
                end else begin
                    n_state = r_is_free ? ffha_pkg::S_DONE : ffha_pkg::S_A_FIN;
                end
            end
            ffha_pkg::S_I_WRI: n_state = r_is_free ? ffha_pkg::S_DONE : ffha_pkg::S_A_FIN;
            ffha_pkg::S_FIX_RD: n_state = ffha_pkg::S_FIX_WR;
            ffha_pkg::S_FIX_WR: n_state = r_ret;
            ffha_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = ffha_pkg::S_IDLE;
                end
            end
            default: n_state = ffha_pkg::S_IDLE;
        endcase
    end

    // memory port and status outputs
    always_comb begin
        ffha_pkg::t_hdr fx;
        fx = rd;
        if (r_fix_nxt) begin
            fx.next = r_fix_val;
        end else begin
            fx.prev = r_fix_val;
        end
        o_ram.we    = 1'b0;
        o_ram.waddr = r_xi;
        o_ram.wdata = r_xh;
        o_ram.raddr = r_it[GW-1:0];
        case (r_state)
            ffha_pkg::S_F_RD:   o_ram.raddr = r_g;
            ffha_pkg::S_I_MXRD: o_ram.raddr = r_xh.next[GW-1:0];
            ffha_pkg::S_FIX_RD: o_ram.raddr = r_fix_addr;
            ffha_pkg::S_FIX_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_fix_addr;
                o_ram.wdata = fx;
            end
            ffha_pkg::S_A_FIN: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_g;
                o_ram.wdata = '{prev: ffha_pkg::NIL, next: ffha_pkg::NIL,
                                used: 1'b1, size: r_gh.size};
            end
            ffha_pkg::S_I_WRX: o_ram.we = 1'b1;
            ffha_pkg::S_I_WRI: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_it[GW-1:0];
                o_ram.wdata = r_ih;
            end
            default: o_ram.we = 1'b0;
        endcase
        o_stat.idle      = (r_state == ffha_pkg::S_IDLE);
        o_stat.res_valid = (r_state == ffha_pkg::S_DONE);
        o_result = '{live: r_live, used_total: r_used, data_addr: r_daddr, status: r_status};
    end

    // datapath
    always_comb begin
        logic [SW-1:0] sp;
        sp         = '0;
        n_ret      = r_ret;
        n_is_free  = r_is_free;
        n_size     = r_size;
        n_adj      = r_adj;
        n_head     = r_head;
        n_it       = r_it;
        n_brk      = r_brk;
        n_used     = r_used;
        n_live     = r_live;
        n_g        = r_g;
        n_xi       = r_xi;
        n_gh       = r_gh;
        n_xh       = r_xh;
        n_ih       = r_ih;
        n_has_it   = r_has_it;
        n_fix_addr = r_fix_addr;
        n_fix_nxt  = r_fix_nxt;
        n_fix_val  = r_fix_val;
        n_status   = r_status;
        n_daddr    = r_daddr;
        n_addr     = r_addr;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                if (i_start) begin
                    n_is_free = i_req_free;
                    n_size    = ({1'b0, i_req_bytes} + SW'(7)) & ~SW'(7);
                    n_addr    = i_free_addr;
                    n_daddr   = '0;
                end
            end
            ffha_pkg::S_A_PRE: begin
                n_adj    = ffha_pkg::span(r_size);
                n_it     = r_head;
                n_status = (r_size == '0) ? ffha_pkg::ST_ZERO : ffha_pkg::ST_OOM;
            end
            ffha_pkg::S_A_WCHK: begin
                if (w_fit) begin
                    n_g  = r_it[GW-1:0];
                    n_gh = rd;
                end else begin
                    n_it = rd.next;
                end
            end
            ffha_pkg::S_A_RM: begin
                if (r_head == {1'b0, r_g}) begin
                    n_head = r_gh.next;
                end
                n_fix_addr = r_gh.prev[GW-1:0];
                n_fix_nxt  = 1'b1;
                n_fix_val  = r_gh.next;
                n_ret      = ffha_pkg::S_A_RM2;
            end
            ffha_pkg::S_A_RM2: begin
                n_fix_addr = r_gh.next[GW-1:0];
                n_fix_nxt  = 1'b0;
                n_fix_val  = r_gh.prev;
                n_ret      = ffha_pkg::S_A_SPLIT;
            end
            ffha_pkg::S_A_SPLIT: begin
                if (w_split_ok && w_rem_ok) begin
                    n_xi      = w_rem[GW-1:0];
                    n_xh      = '{prev: ffha_pkg::NIL, next: ffha_pkg::NIL,
                                  used: 1'b0, size: w_diff[ZW-1:0]};
                    n_gh.size = r_size[ZW-1:0];
                end
            end
            ffha_pkg::S_A_BRK: begin
                if (!w_oom) begin
                    n_g   = r_brk[GW+2:3];
                    n_brk = w_brk_end[16:0];
                    n_gh  = '{prev: ffha_pkg::NIL, next: ffha_pkg::NIL,
                              used: 1'b1, size: r_size[ZW-1:0]};
                end
            end
            ffha_pkg::S_A_FIN: begin
                n_used   = r_used + r_gh.size;
                n_live   = r_live + 12'd1;
                n_daddr  = {r_g, 3'b000} + 16'd8;
                n_status = ffha_pkg::ST_OK;
            end
            ffha_pkg::S_F_PRE: begin
                n_status = w_null ? ffha_pkg::ST_NULL : ffha_pkg::ST_FREED;
                n_g      = r_addr[15:3] - GW'(1);
            end
            ffha_pkg::S_F_CHK: begin
                if (rd.used) begin
                    n_used   = r_used - rd.size;
                    n_live   = r_live - 12'd1;
                    n_status = ffha_pkg::ST_OK;
                    n_xi     = r_g;
                    n_xh     = '{prev: ffha_pkg::NIL, next: ffha_pkg::NIL, used: 1'b0,
                                 size: (rd.size < ZW'(ffha_pkg::LINK_BYTES))
                                       ? ZW'(ffha_pkg::LINK_BYTES) : rd.size};
                end
            end
            ffha_pkg::S_I_START: begin
                n_has_it = 1'b0;
                if (!w_head_ok) begin
                    n_head = {1'b0, r_xi};
                end else if (r_xi < r_head[GW-1:0]) begin
                    // new block becomes the list head
                    n_xh.next  = r_head;
                    n_head     = {1'b0, r_xi};
                    n_fix_addr = r_head[GW-1:0];
                    n_fix_nxt  = 1'b0;
                    n_fix_val  = {1'b0, r_xi};
                    n_ret      = ffha_pkg::S_I_MX;
                end else begin
                    n_it = r_head;
                end
            end
            ffha_pkg::S_I_WCHK: begin
                if (w_walk_on) begin
                    n_it = rd.next;
                end else begin
                    n_ih       = rd;
                    n_ih.next  = {1'b0, r_xi};
                    n_xh.prev  = r_it;
                    n_xh.next  = rd.next;
                    n_has_it   = 1'b1;
                    n_fix_addr = rd.next[GW-1:0];
                    n_fix_nxt  = 1'b0;
                    n_fix_val  = {1'b0, r_xi};
                    n_ret      = ffha_pkg::S_I_MX;
                end
            end
            ffha_pkg::S_I_MXMRG: begin
                sp         = ffha_pkg::span({1'b0, rd.size});
                n_xh.size  = r_xh.size + sp[ZW-1:0];
                n_xh.next  = rd.next;
                n_fix_addr = rd.next[GW-1:0];
                n_fix_nxt  = 1'b0;
                n_fix_val  = {1'b0, r_xi};
                n_ret      = ffha_pkg::S_I_MI;
            end
            ffha_pkg::S_I_MI: begin
                if (w_mi) begin
                    sp         = ffha_pkg::span({1'b0, r_xh.size});
                    n_ih.size  = r_ih.size + sp[ZW-1:0];
                    n_ih.next  = r_xh.next;
                    n_fix_addr = r_xh.next[GW-1:0];
                    n_fix_nxt  = 1'b0;
                    n_fix_val  = r_it;
                    n_ret      = ffha_pkg::S_I_WRX;
                end
            end
            default: n_status = r_status;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_IDLE;
            r_head  <= ffha_pkg::NIL;
            r_brk   <= '0;
            r_used  <= '0;
            r_live  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_brk   <= n_brk;
            r_used  <= n_used;
            r_live  <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret      <= n_ret;
        r_is_free  <= n_is_free;
        r_size     <= n_size;
        r_adj      <= n_adj;
        r_it       <= n_it;
        r_g        <= n_g;
        r_xi       <= n_xi;
        r_gh       <= n_gh;
        r_xh       <= n_xh;
        r_ih       <= n_ih;
        r_has_it   <= n_has_it;
        r_fix_addr <= n_fix_addr;
        r_fix_nxt  <= n_fix_nxt;
        r_fix_val  <= n_fix_val;
        r_status   <= n_status;
        r_daddr    <= n_daddr;
        r_addr     <= n_addr;
    end

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Allocate and free requests on a heap of 8-byte granules, address-ordered
// first-fit free list with splitting and coalescing.
// ----------------------------------------------------------------------------
// steps: a request rejected by its size or address goes straight to the result; an
//   allocate walks the free list node by node, a free walks it to its insertion point
//   and then updates the neighbor links, all through the header memory port
// throughput: one request at a time, the next is accepted once the result is
//   handed to the output register
// reset: list empty, break offset and counters zero, heap_bytes 65536;
//   header memory is not cleared
`default_nettype none

module first_fit_heap_allocator (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire [ffha_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire                       i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire [39:0]                i_s_axis_tdata,  // request_bytes, free_addr
    input  wire                       i_s_axis_tuser,  // req_type
    output logic                      o_m_axis_tvalid,
    input  wire                       i_m_axis_tready,
    output logic [47:0]               o_m_axis_tdata   // status, data_addr,
                                                       // used_total, live_allocations
);

    logic [ffha_pkg::CFG_W-1:0] r_heap;
    logic                       r_out_valid;
    ffha_pkg::t_result          r_out;
    ffha_pkg::t_eng_stat        eng_stat;
    ffha_pkg::t_result          eng_res;
    ffha_pkg::t_ram_req         ram_req;
    ffha_pkg::t_hdr             ram_rdata;
    logic                       in_beat, res_take;

    assign o_s_axis_tready = eng_stat.idle;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign res_take        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap <= ffha_pkg::HEAP_RESET;
        end else if (i_cfg_we) begin
            r_heap <= i_cfg_wdata;
        end
    end

    // output register frees the engine while a result beat waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_stat.res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_stat.res_valid && res_take) begin
            r_out <= eng_res;
        end
    end

    ffha_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_beat),
        .i_req_free   (i_s_axis_tuser),
        .i_req_bytes  (i_s_axis_tdata[16:0]),
        .i_free_addr  (i_s_axis_tdata[32:17]),
        .i_heap_bytes (r_heap),
        .i_res_take   (res_take),
        .o_stat       (eng_stat),
        .o_result     (eng_res),
        .o_ram        (ram_req),
        .i_ram_rdata  (ram_rdata)
    );

    ffha_hdr_ram u_hdr_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
